@@ rtl/core/xtea_pkg.sv @@
// ----------------------------------------------------------------------------
// xtea_pkg
// shared types and constants for the xtea block cipher core
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int WORD_W    = 32;
    localparam int BLOCK_W   = 2 * WORD_W;
    localparam int RC_W      = 9;   // round_count register width
    localparam int CFG_IDX_W = 3;   // register index width

    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [3:0][WORD_W-1:0] t_key;

    localparam t_word          GOLDEN_DELTA   = 32'h9e37_79b9;
    localparam logic [RC_W-1:0] BASE_ROUNDS    = 9'd32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 3'd5;

    // control of one half-round of the shared unit
    typedef struct packed {
        logic sub;      // subtract (decrypt) instead of add
        logic key_hi;   // key select from sum bits 12:11 instead of 1:0
    } t_half_ctl;

endpackage

@@ rtl/core/xtea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// xtea_block_cipher
// 64-bit xtea encrypt/decrypt core with one shared half-round unit
// ----------------------------------------------------------------------------
// N = effective rounds (32 by default); each round takes two half-rounds
// through the shared xtea_round unit, one half-round per clock unless the
// final half-round waits for an unread result; a new block is taken only when
// idle, and the output register holds a result while the next block is taken
// reset: synchronous active-low; keys clear to zero, rounds 32, encrypt mode
module xtea_block_cipher #(
    parameter int ROUND_LIMIT = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [xtea_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]     i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [xtea_pkg::BLOCK_W-1:0]    s_axis_tdata,  // block_high, block_low
    input  logic                            s_axis_tlast,  // last_in
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [xtea_pkg::BLOCK_W-1:0]    m_axis_tdata,  // result_high, result_low
    output logic                            m_axis_tlast   // last_out
);
    import xtea_pkg::*;

    localparam int CNT_W  = $clog2(ROUND_LIMIT + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // configuration registers
    t_key             r_key;
    logic [RC_W-1:0]  r_rounds;
    logic             r_decrypt;

    // sequencer and datapath
    t_state           r_state;
    logic             r_phase;      // 0: first half-round, 1: second
    logic [CNT_W-1:0] r_left;       // feistel cycles still to run
    t_word            r_v0;
    t_word            r_v1;
    t_word            r_sum;
    logic             r_last;

    // output register
    logic                 r_out_valid;
    logic [BLOCK_W-1:0]   r_out_data;
    logic                 r_out_last;

    logic              w_accept;
    logic [RC_W-1:0]   w_n;
    t_word             w_sum_init;
    t_half_ctl         w_ctl;
    logic              w_dst_v0;
    t_word             w_src;
    t_word             w_dst;
    t_word             w_new;
    logic              w_done;
    logic              w_hold;
    logic              n_out_valid;

    // effective round count: zero means default, saturate at the limit
    always_comb begin
        if (r_rounds == '0) begin
            w_n = BASE_ROUNDS;
        end else if (r_rounds > RC_W'(ROUND_LIMIT)) begin
            w_n = RC_W'(ROUND_LIMIT);
        end else begin
            w_n = r_rounds;
        end
        // decrypt starts its sum at N * delta modulo 2^32
        w_sum_init = t_word'(w_n) * GOLDEN_DELTA;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // half-round routing: encrypt updates v0 then v1, decrypt v1 then v0
    always_comb begin
        w_ctl.sub    = r_decrypt;
        w_ctl.key_hi = r_phase ^ r_decrypt;
        w_dst_v0     = ~(r_phase ^ r_decrypt);
        w_src        = w_dst_v0 ? r_v1 : r_v0;
        w_dst        = w_dst_v0 ? r_v0 : r_v1;
        w_done       = r_phase && (r_left == CNT_W'(1));
        // final half-round waits while the previous result is still unread
        w_hold       = w_done && r_out_valid && !m_axis_tready;
        // result beat stays until taken, a finished block loads a new one
        n_out_valid  = (r_out_valid && !m_axis_tready) ||
                       ((r_state == ST_RUN) && w_done && !w_hold);
    end

    xtea_round u_round (
        .i_src (w_src),
        .i_dst (w_dst),
        .i_sum (r_sum),
        .i_key (r_key),
        .i_ctl (w_ctl),
        .o_dst (w_new)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_rounds  <= BASE_ROUNDS;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY0:    r_key[0]  <= i_cfg_data;
                REG_KEY1:    r_key[1]  <= i_cfg_data;
                REG_KEY2:    r_key[2]  <= i_cfg_data;
                REG_KEY3:    r_key[3]  <= i_cfg_data;
                REG_ROUNDS:  r_rounds  <= i_cfg_data[RC_W-1:0];
                REG_DECRYPT: r_decrypt <= i_cfg_data[0];
                default: ;   // unknown index, ignored
            endcase
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RUN;
                        r_phase <= 1'b0;
                        r_left  <= CNT_W'(w_n);
                        r_v0    <= s_axis_tdata[WORD_W-1:0];
                        r_v1    <= s_axis_tdata[BLOCK_W-1:WORD_W];
                        r_last  <= s_axis_tlast;
                        r_sum   <= r_decrypt ? w_sum_init : '0;
                    end
                end
                ST_RUN: begin
                    if (!w_hold) begin
                        if (w_dst_v0) begin
                            r_v0 <= w_new;
                        end else begin
                            r_v1 <= w_new;
                        end
                        // sum steps once per feistel cycle, after the first half
                        if (!r_phase) begin
                            r_sum <= r_decrypt ? (r_sum - GOLDEN_DELTA)
                                               : (r_sum + GOLDEN_DELTA);
                        end else begin
                            r_left <= r_left - CNT_W'(1);
                        end
                        r_phase <= ~r_phase;
                        if (w_done) begin
                            r_state     <= ST_IDLE;
                            r_out_last  <= r_last;
                            r_out_data  <= w_dst_v0 ? {r_v1, w_new} : {w_new, r_v0};
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ rtl/core/xtea_round.sv @@
// ----------------------------------------------------------------------------
// xtea_round
// one xtea half-round: mixes the source word into the destination word
// ----------------------------------------------------------------------------
module xtea_round (
    input  xtea_pkg::t_word    i_src,
    input  xtea_pkg::t_word    i_dst,
    input  xtea_pkg::t_word    i_sum,
    input  xtea_pkg::t_key     i_key,
    input  xtea_pkg::t_half_ctl i_ctl,
    output xtea_pkg::t_word    o_dst
);
    import xtea_pkg::*;

    t_word w_mix;
    t_word w_keyed;
    t_word w_term;
    logic [1:0] w_kidx;

    always_comb begin
        w_kidx  = i_ctl.key_hi ? i_sum[12:11] : i_sum[1:0];
        w_mix   = ((i_src << 4) ^ (i_src >> 5)) + i_src;
        w_keyed = i_sum + i_key[w_kidx];
        w_term  = w_mix ^ w_keyed;
        o_dst   = i_ctl.sub ? (i_dst - w_term) : (i_dst + w_term);
    end

endmodule

@@ rtl/core/xtea_checker.sv @@
// ----------------------------------------------------------------------------
// xtea_checker
// port-level checks of the xtea core, bound to the top level
// ----------------------------------------------------------------------------
module xtea_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [xtea_pkg::BLOCK_W-1:0] m_axis_tdata,
    input logic                         m_axis_tlast
);
    import xtea_pkg::*;

    // reset leaves the core empty and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("core not idle after reset");

    // the input stays not ready while the first round of a taken block runs
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while a block is in progress");

    // finishing a block always leaves a result on the output
    a_result_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid)
        else $error("block finished without a result");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output beat changed");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
